>>> rtl/snfc_pkg.sv
// Shared types and constants for the sequence number flow checker.
`default_nettype none

package snfc_pkg;

  localparam int SEQ_W = 16;
  localparam int RUN_W = 17;
  localparam int CNT_W = 32;

  localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    EV_IN_ORDER = 2'd0,
    EV_GAP      = 2'd1,
    EV_DUP      = 2'd2,
    EV_REVERSED = 2'd3
  } event_kind_t;

  typedef struct packed {
    logic [SEQ_W-1:0] last_seq;
    logic [RUN_W-1:0] run_len;
    logic [RUN_W-1:0] longest_run;
    logic             torn;
    logic [SEQ_W-1:0] lost_last;
    logic [CNT_W-1:0] lost_sum;
    logic [CNT_W-1:0] gap_total;
    logic [CNT_W-1:0] dup_total;
    logic [CNT_W-1:0] reverse_total;
  } flow_state_t;

  typedef struct packed {
    logic             accepted;
    event_kind_t      event_kind;
    logic             torn;
    logic [SEQ_W-1:0] lost_frames;
    logic [CNT_W-1:0] total_lost;
    logic [RUN_W-1:0] run_length;
    logic [RUN_W-1:0] max_run;
    logic [RUN_W-1:0] prior_run;
    logic [CNT_W-1:0] gap_count;
    logic [CNT_W-1:0] duplicate_count;
    logic [CNT_W-1:0] order_errors;
  } flow_result_t;

endpackage

`default_nettype wire

>>> rtl/snfc_in_if.sv
// Input channel interface: one sequence number per item.
`default_nettype none

interface snfc_in_if import snfc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SEQ_W-1:0] seq_num;

  modport source(output valid, output seq_num, input ready);
  modport sink(input valid, input seq_num, output ready);
endinterface

`default_nettype wire

>>> rtl/snfc_out_if.sv
// Result channel interface: verdict and flow statistics per item.
`default_nettype none

interface snfc_out_if import snfc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             accepted;
  logic [1:0]       event_kind;
  logic             torn;
  logic [SEQ_W-1:0] lost_frames;
  logic [CNT_W-1:0] total_lost;
  logic [RUN_W-1:0] run_length;
  logic [RUN_W-1:0] max_run;
  logic [RUN_W-1:0] prior_run;
  logic [CNT_W-1:0] gap_count;
  logic [CNT_W-1:0] duplicate_count;
  logic [CNT_W-1:0] order_errors;

  modport source(output valid, output accepted, output event_kind, output torn,
                 output lost_frames, output total_lost, output run_length,
                 output max_run, output prior_run, output gap_count,
                 output duplicate_count, output order_errors, input ready);
  modport sink(input valid, input accepted, input event_kind, input torn,
               input lost_frames, input total_lost, input run_length,
               input max_run, input prior_run, input gap_count,
               input duplicate_count, input order_errors, output ready);
endinterface

`default_nettype wire

>>> rtl/snfc_in_reg.sv
// Input register stage: captures one sequence number per accepted item.
`default_nettype none

module snfc_in_reg import snfc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  snfc_in_if.sink          in_ch,
  input  logic             advance,
  output logic             vld,
  output logic [SEQ_W-1:0] seq
);

  logic             vld_r;
  logic [SEQ_W-1:0] seq_r;

  // Take a new item when empty or when the held one moves on this cycle.
  assign in_ch.ready = !vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      seq_r <= in_ch.seq_num;
    end
  end

  assign vld = vld_r;
  assign seq = seq_r;

endmodule

`default_nettype wire

>>> rtl/snfc_eval.sv
// Classification and statistics update for one sequence number.
`default_nettype none

module snfc_eval import snfc_pkg::*; (
  input  logic [SEQ_W-1:0] seq,
  input  flow_state_t      st,
  output flow_state_t      st_nxt,
  output flow_result_t     res
);

  logic [SEQ_W:0]   seq_ext;
  logic [SEQ_W:0]   prev_inc;
  logic [SEQ_W-1:0] lost;
  logic [CNT_W:0]   lost_sum_wide;
  logic             acc;
  event_kind_t      kind;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  assign seq_ext       = {1'b0, seq};
  assign prev_inc      = {1'b0, st.last_seq} + 1'b1;
  assign lost          = seq - st.last_seq - 1'b1;
  assign lost_sum_wide = {1'b0, st.lost_sum} + {{(CNT_W + 1 - SEQ_W){1'b0}}, lost};

  always_comb begin
    st_nxt = st;
    acc    = 1'b0;
    kind   = EV_DUP;
    if (seq < st.last_seq) begin
      kind                 = EV_REVERSED;
      st_nxt.reverse_total = sat_inc(st.reverse_total);
      st_nxt.run_len       = RUN_W'(1);
    end else if (seq_ext == prev_inc) begin
      kind             = EV_IN_ORDER;
      acc              = 1'b1;
      st_nxt.torn      = 1'b0;
      st_nxt.lost_last = '0;
      if (st.run_len != RUN_MAX) begin
        st_nxt.run_len = st.run_len + 1'b1;
      end
      if (st_nxt.run_len > st.longest_run) begin
        st_nxt.longest_run = st_nxt.run_len;
      end
    end else if (seq_ext > prev_inc) begin
      kind             = EV_GAP;
      acc              = 1'b1;
      st_nxt.torn      = 1'b1;
      st_nxt.gap_total = sat_inc(st.gap_total);
      st_nxt.lost_last = lost;
      st_nxt.lost_sum  = lost_sum_wide[CNT_W] ? CNT_MAX : lost_sum_wide[CNT_W-1:0];
      st_nxt.run_len   = RUN_W'(1);
    end else begin
      // Equal numbers: a repeated zero is accepted and restarts the run; other repeats are duplicates.
      st_nxt.torn = 1'b0;
      if (st.last_seq == '0) begin
        acc            = 1'b1;
        st_nxt.run_len = RUN_W'(1);
      end else begin
        st_nxt.dup_total = sat_inc(st.dup_total);
      end
    end
    st_nxt.last_seq = seq;
  end

  always_comb begin
    res.accepted        = acc;
    res.event_kind      = kind;
    res.torn            = st_nxt.torn;
    res.lost_frames     = st_nxt.lost_last;
    res.total_lost      = st_nxt.lost_sum;
    res.run_length      = st_nxt.run_len;
    res.max_run         = st_nxt.longest_run;
    res.prior_run       = st.run_len;
    res.gap_count       = st_nxt.gap_total;
    res.duplicate_count = st_nxt.dup_total;
    res.order_errors    = st_nxt.reverse_total;
  end

endmodule

`default_nettype wire

>>> rtl/snfc_out_reg.sv
// Result register stage: holds one result item until the sink takes it.
`default_nettype none

module snfc_out_reg import snfc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load_vld,
  input  flow_result_t res,
  output logic         advance,
  snfc_out_if.source   out_ch
);

  logic         vld_r;
  flow_result_t res_r;

  // Move on when the register is empty or its item is being taken.
  assign advance = !vld_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (advance) begin
      vld_r <= load_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load_vld) begin
      res_r <= res;
    end
  end

  assign out_ch.valid           = vld_r;
  assign out_ch.accepted        = res_r.accepted;
  assign out_ch.event_kind      = res_r.event_kind;
  assign out_ch.torn            = res_r.torn;
  assign out_ch.lost_frames     = res_r.lost_frames;
  assign out_ch.total_lost      = res_r.total_lost;
  assign out_ch.run_length      = res_r.run_length;
  assign out_ch.max_run         = res_r.max_run;
  assign out_ch.prior_run       = res_r.prior_run;
  assign out_ch.gap_count       = res_r.gap_count;
  assign out_ch.duplicate_count = res_r.duplicate_count;
  assign out_ch.order_errors    = res_r.order_errors;

endmodule

`default_nettype wire

>>> rtl/sequence_number_flow_checker.sv
// Top level of the sequence number flow checker.
//
//  channel | direction | payload                                   | handshake
//  in_ch   | in        | seq_num                                   | valid/ready
//  out_ch  | out       | verdict, run lengths, lost and error counts| valid/ready
//
// One item per cycle while the sink takes results; a result is valid once its item
// has passed the input register, then evaluation into the result register.
// The flow state updates in the cycle an item moves into the result register.
// Reset (rst_n low, synchronous) empties both stages and clears all statistics.
// A stalled result holds; the input stage keeps taking items while it can move.
`default_nettype none

module sequence_number_flow_checker import snfc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  snfc_in_if.sink    in_ch,
  snfc_out_if.source out_ch
);

  logic             advance;
  logic             item_vld;
  logic [SEQ_W-1:0] item_seq;
  logic             fire;
  flow_state_t      st_r;
  flow_state_t      st_nxt;
  flow_result_t     res;

  snfc_in_reg u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (advance),
    .vld     (item_vld),
    .seq     (item_seq)
  );

  snfc_eval u_eval (
    .seq    (item_seq),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  snfc_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load_vld (item_vld),
    .res      (res),
    .advance  (advance),
    .out_ch   (out_ch)
  );

  assign fire = item_vld && advance;

  // Commit the flow state only when the item moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/snfc_checker.sv
// Port-level assertions for the sequence number flow checker, with bind.
`default_nettype none

module snfc_checker import snfc_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic             accepted,
  input logic [1:0]       event_kind,
  input logic             torn,
  input logic [SEQ_W-1:0] lost_frames,
  input logic [RUN_W-1:0] run_length
);

  // A pending result must not drop before it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (event_kind == EV_IN_ORDER) |-> accepted && !torn)
    else $error("in-order item not accepted or flow marked torn");

  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (event_kind == EV_GAP) |->
      accepted && torn && (lost_frames != '0) && (run_length == RUN_W'(1)))
    else $error("gap item with inconsistent statistics");

  a_reversed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (event_kind == EV_REVERSED) |-> !accepted && (run_length == RUN_W'(1)))
    else $error("reversed item accepted or run not restarted");

endmodule

bind sequence_number_flow_checker snfc_checker u_snfc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .accepted    (out_ch.accepted),
  .event_kind  (out_ch.event_kind),
  .torn        (out_ch.torn),
  .lost_frames (out_ch.lost_frames),
  .run_length  (out_ch.run_length)
);

`default_nettype wire
